// File: design/tick_history_table_defines.svh
// Assertion macros used by the tick history table top level.
`ifndef TICK_HISTORY_TABLE_DEFINES_SVH
`define TICK_HISTORY_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define THT_ASSERT_HOLDS(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tick history table check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define THT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tick history table check failed");

`endif

// File: design/tht_pkg.sv
// Shared types and constants of the tick history table.
package tht_pkg;

    localparam int CMD_W               = 3;
    localparam int TICK_W              = 31;
    localparam int COUNT_OUT_W         = 7;
    localparam int STATUS_W            = 2;
    localparam int DEFAULT_TABLE_DEPTH = 64;
    localparam int DEFAULT_DATA_BITS   = 64;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE    = 3'd0,
        CMD_READ     = 3'd1,
        CMD_CLOSEST  = 3'd2,
        CMD_TRIM     = 3'd3,
        CMD_ERASE    = 3'd4,
        CMD_CLEAR    = 3'd5,
        CMD_EARLIEST = 3'd6,
        CMD_LATEST   = 3'd7
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    // control from the sequencer to the scan datapath
    typedef struct packed {
        logic clr;   // new item: drop all candidates
        logic vld;   // memory read data valid this cycle
    } scan_ctl_t;

    // what the scan has found so far
    typedef struct packed {
        logic exact;  // key equal to the request
        logic free;   // an invalid slot
        logic any;    // at least one valid entry
        logic below;  // a valid key below the request
    } scan_flags_t;

endpackage

// File: design/tht_mem.sv
// Entry store: simple dual-port synchronous RAM, registered read.
module tht_mem #(
    parameter int DEPTH = tht_pkg::DEFAULT_TABLE_DEPTH,
    parameter int WIDTH = 1 + tht_pkg::TICK_W + tht_pkg::DEFAULT_DATA_BITS
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/tht_scan.sv
// Scan datapath: tracks exact, free, min, max and floor candidates over one pass, and counts valid and below entries.
module tht_scan #(
    parameter int TABLE_DEPTH = tht_pkg::DEFAULT_TABLE_DEPTH,
    parameter int DATA_BITS   = tht_pkg::DEFAULT_DATA_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  tht_pkg::scan_ctl_t                 ctl,
    input  logic [tht_pkg::TICK_W-1:0]         tick,
    input  logic [$clog2(TABLE_DEPTH)-1:0]     rd_addr,
    input  logic                               rd_valid,
    input  logic [tht_pkg::TICK_W-1:0]         rd_key,
    input  logic [DATA_BITS-1:0]               rd_data,
    output tht_pkg::scan_flags_t               flags,
    output logic [$clog2(TABLE_DEPTH)-1:0]     exact_idx,
    output logic [DATA_BITS-1:0]               exact_data,
    output logic [$clog2(TABLE_DEPTH)-1:0]     free_idx,
    output logic [tht_pkg::TICK_W-1:0]         min_key,
    output logic [DATA_BITS-1:0]               min_data,
    output logic [tht_pkg::TICK_W-1:0]         max_key,
    output logic [DATA_BITS-1:0]               max_data,
    output logic [tht_pkg::TICK_W-1:0]         below_key,
    output logic [DATA_BITS-1:0]               below_data,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]   valid_cnt,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]   below_cnt
);
    import tht_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    scan_flags_t         flags_reg;
    logic [CW-1:0]       valid_cnt_reg;
    logic [CW-1:0]       below_cnt_reg;
    logic [AW-1:0]       exact_idx_reg;
    logic [DATA_BITS-1:0] exact_data_reg;
    logic [AW-1:0]       free_idx_reg;
    logic [TICK_W-1:0]   min_key_reg;
    logic [DATA_BITS-1:0] min_data_reg;
    logic [TICK_W-1:0]   max_key_reg;
    logic [DATA_BITS-1:0] max_data_reg;
    logic [TICK_W-1:0]   below_key_reg;
    logic [DATA_BITS-1:0] below_data_reg;

    logic live;
    logic take_exact;
    logic take_free;
    logic take_min;
    logic take_max;
    logic is_below;
    logic take_below;

    always_comb
    begin
        live       = ctl.vld && rd_valid;
        take_exact = live && (rd_key == tick) && !flags_reg.exact;
        take_free  = ctl.vld && !rd_valid && !flags_reg.free;
        take_min   = live && (!flags_reg.any || (rd_key < min_key_reg));
        take_max   = live && (!flags_reg.any || (rd_key > max_key_reg));
        is_below   = live && (rd_key < tick);
        take_below = is_below && (!flags_reg.below || (rd_key > below_key_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg     <= '0;
            valid_cnt_reg <= '0;
            below_cnt_reg <= '0;
        end
        else if (ctl.clr)
        begin
            flags_reg     <= '0;
            valid_cnt_reg <= '0;
            below_cnt_reg <= '0;
        end
        else
        begin
            if (take_exact)
            begin
                flags_reg.exact <= 1'b1;
            end
            if (take_free)
            begin
                flags_reg.free <= 1'b1;
            end
            if (live)
            begin
                flags_reg.any <= 1'b1;
                valid_cnt_reg <= valid_cnt_reg + CW'(1);
            end
            if (is_below)
            begin
                flags_reg.below <= 1'b1;
                below_cnt_reg   <= below_cnt_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_exact)
        begin
            exact_idx_reg  <= rd_addr;
            exact_data_reg <= rd_data;
        end
        if (take_free)
        begin
            free_idx_reg <= rd_addr;
        end
        if (take_min)
        begin
            min_key_reg  <= rd_key;
            min_data_reg <= rd_data;
        end
        if (take_max)
        begin
            max_key_reg  <= rd_key;
            max_data_reg <= rd_data;
        end
        if (take_below)
        begin
            below_key_reg  <= rd_key;
            below_data_reg <= rd_data;
        end
    end

    assign flags      = flags_reg;
    assign exact_idx  = exact_idx_reg;
    assign exact_data = exact_data_reg;
    assign free_idx   = free_idx_reg;
    assign min_key    = min_key_reg;
    assign min_data   = min_data_reg;
    assign max_key    = max_key_reg;
    assign max_data   = max_data_reg;
    assign below_key  = below_key_reg;
    assign below_data = below_data_reg;
    assign valid_cnt  = valid_cnt_reg;
    assign below_cnt  = below_cnt_reg;

endmodule

// File: design/tick_history_table.sv
// Tick history table top level: sequencer, entry store, scan and result register.
//
// Usage: a keyed table of up to TABLE_DEPTH data words stored under 31-bit ticks.
// Input channel (in_valid/in_ready) carries one command item: cmd, tick, data_word.
// Output channel (out_valid/out_ready) returns exactly one result item per command:
// hit, found_tick, found_data, entry_count and status.
// Every command walks the whole entry RAM once, one entry per cycle through its
// single read port, then waits out the registered read in S_DRAIN and decides and
// writes back in S_FINISH. A new item is taken only once the last one has left
// S_FINISH and the block is back in S_IDLE.
// Trim and clear invalidate entries during the walk through the RAM write port;
// write and erase do their single write in the final cycle.
// After reset the block clears the RAM, one entry per cycle, with in_ready low;
// the table then starts empty.
// The result sits in an output register, so the next command can be accepted and
// scanned while a result waits; if out_ready is still low when the next result is
// ready, the block holds in its final cycle until the register frees up.
module tick_history_table #(
    parameter int TABLE_DEPTH = tht_pkg::DEFAULT_TABLE_DEPTH,
    parameter int DATA_BITS   = tht_pkg::DEFAULT_DATA_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [tht_pkg::CMD_W-1:0]        cmd,
    input  logic [tht_pkg::TICK_W-1:0]       tick,
    input  logic [DATA_BITS-1:0]             data_word,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             hit,
    output logic [tht_pkg::TICK_W-1:0]       found_tick,
    output logic [DATA_BITS-1:0]             found_data,
    output logic [tht_pkg::COUNT_OUT_W-1:0]  entry_count,
    output logic [tht_pkg::STATUS_W-1:0]     status
);
    import tht_pkg::*;

`include "tick_history_table_defines.svh"

    localparam int AW     = $clog2(TABLE_DEPTH);
    localparam int CW     = $clog2(TABLE_DEPTH + 1);
    localparam int WORD_W = 1 + TICK_W + DATA_BITS;   // {valid, key, data}

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } state_t;

    state_t               state_reg;
    logic [AW-1:0]        idx_reg;
    logic                 dv_reg;
    logic [AW-1:0]        dv_addr_reg;
    cmd_t                 cmd_reg;
    logic [TICK_W-1:0]    tick_reg;
    logic [DATA_BITS-1:0] data_reg;

    logic                 out_valid_reg;
    logic                 hit_reg;
    logic [TICK_W-1:0]    found_tick_reg;
    logic [DATA_BITS-1:0] found_data_reg;
    logic [COUNT_OUT_W-1:0] count_reg;
    status_t              status_reg;

    // RAM ports
    logic                 mem_wr_en;
    logic [AW-1:0]        mem_wr_addr;
    logic [WORD_W-1:0]    mem_wr_word;
    logic                 mem_rd_en;
    logic [WORD_W-1:0]    mem_rd_word;

    logic                 rd_valid;
    logic [TICK_W-1:0]    rd_key;
    logic [DATA_BITS-1:0] rd_data;

    // scan results
    scan_ctl_t            scan_ctl;
    scan_flags_t          flags;
    logic [AW-1:0]        exact_idx;
    logic [DATA_BITS-1:0] exact_data;
    logic [AW-1:0]        free_idx;
    logic [TICK_W-1:0]    min_key;
    logic [DATA_BITS-1:0] min_data;
    logic [TICK_W-1:0]    max_key;
    logic [DATA_BITS-1:0] max_data;
    logic [TICK_W-1:0]    below_key;
    logic [DATA_BITS-1:0] below_data;
    logic [CW-1:0]        valid_cnt;
    logic [CW-1:0]        below_cnt;

    // final-cycle decision
    logic                 out_free;
    logic                 accept;
    logic                 fin_go;
    logic                 fin_hit;
    logic [TICK_W-1:0]    fin_tick;
    logic [DATA_BITS-1:0] fin_data;
    status_t              fin_status;
    logic [CW-1:0]        fin_count;
    logic                 fin_wr;
    logic [AW-1:0]        fin_wr_addr;
    logic [WORD_W-1:0]    fin_wr_word;

    assign rd_valid = mem_rd_word[WORD_W-1];
    assign rd_key   = mem_rd_word[WORD_W-2 -: TICK_W];
    assign rd_data  = mem_rd_word[DATA_BITS-1:0];

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign fin_go    = (state_reg == S_FINISH) && out_free;
    assign mem_rd_en = (state_reg == S_SCAN);

    assign scan_ctl.clr = accept;
    assign scan_ctl.vld = dv_reg;

    tht_mem #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (WORD_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_word),
        .rd_en   (mem_rd_en),
        .rd_addr (idx_reg),
        .rd_data (mem_rd_word)
    );

    tht_scan #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .DATA_BITS   (DATA_BITS)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (scan_ctl),
        .tick       (tick_reg),
        .rd_addr    (dv_addr_reg),
        .rd_valid   (rd_valid),
        .rd_key     (rd_key),
        .rd_data    (rd_data),
        .flags      (flags),
        .exact_idx  (exact_idx),
        .exact_data (exact_data),
        .free_idx   (free_idx),
        .min_key    (min_key),
        .min_data   (min_data),
        .max_key    (max_key),
        .max_data   (max_data),
        .below_key  (below_key),
        .below_data (below_data),
        .valid_cnt  (valid_cnt),
        .below_cnt  (below_cnt)
    );

    // Result and single write-back, decided once the scan is complete.
    always_comb
    begin
        fin_hit     = 1'b0;
        fin_tick    = '0;
        fin_data    = '0;
        fin_status  = ST_OK;
        fin_count   = valid_cnt;
        fin_wr      = 1'b0;
        fin_wr_addr = exact_idx;
        fin_wr_word = '0;
        unique case (cmd_reg)
            CMD_WRITE:
            begin
                fin_wr_word = {1'b1, tick_reg, data_reg};
                if (flags.exact)
                begin
                    fin_wr = 1'b1;   // overwrite, even when full
                end
                else if (flags.free)
                begin
                    fin_wr      = 1'b1;
                    fin_wr_addr = free_idx;
                    fin_count   = valid_cnt + CW'(1);
                end
                else
                begin
                    fin_status = ST_FULL;
                end
            end
            CMD_READ:
            begin
                if (flags.exact)
                begin
                    fin_hit  = 1'b1;
                    fin_tick = tick_reg;
                    fin_data = exact_data;
                end
                else
                begin
                    fin_status = ST_MISS;
                end
            end
            CMD_CLOSEST:
            begin
                fin_hit = 1'b1;
                if (flags.exact)
                begin
                    fin_tick = tick_reg;
                    fin_data = exact_data;
                end
                else if (!flags.any)
                begin
                    fin_hit    = 1'b0;
                    fin_status = ST_MISS;
                end
                else if (tick_reg < min_key)
                begin
                    fin_tick = min_key;
                    fin_data = min_data;
                end
                else if (tick_reg > max_key)
                begin
                    fin_tick = max_key;
                    fin_data = max_data;
                end
                else
                begin
                    // between earliest and latest: floor key
                    fin_tick = below_key;
                    fin_data = below_data;
                end
            end
            CMD_TRIM:
            begin
                fin_count = valid_cnt - below_cnt;
            end
            CMD_ERASE:
            begin
                if (flags.exact)
                begin
                    fin_hit   = 1'b1;
                    fin_tick  = tick_reg;
                    fin_data  = exact_data;
                    fin_wr    = 1'b1;
                    fin_count = valid_cnt - CW'(1);
                end
                else
                begin
                    fin_status = ST_MISS;
                end
            end
            CMD_CLEAR:
            begin
                fin_count = '0;
            end
            CMD_EARLIEST:
            begin
                if (flags.any)
                begin
                    fin_hit  = 1'b1;
                    fin_tick = min_key;
                    fin_data = min_data;
                end
                else
                begin
                    fin_status = ST_MISS;
                end
            end
            CMD_LATEST:
            begin
                if (flags.any)
                begin
                    fin_hit  = 1'b1;
                    fin_tick = max_key;
                    fin_data = max_data;
                end
                else
                begin
                    fin_status = ST_MISS;
                end
            end
        endcase
    end

    // RAM write port: init sweep, trim/clear invalidation during scan, final write.
    always_comb
    begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = dv_addr_reg;
        mem_wr_word = '0;
        if (state_reg == S_INIT)
        begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = idx_reg;
        end
        else if (state_reg == S_FINISH)
        begin
            mem_wr_en   = fin_wr && out_free;
            mem_wr_addr = fin_wr_addr;
            mem_wr_word = fin_wr_word;
        end
        else if (dv_reg)
        begin
            mem_wr_en = rd_valid &&
                        ((cmd_reg == CMD_CLEAR) ||
                         ((cmd_reg == CMD_TRIM) && (rd_key < tick_reg)));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            idx_reg        <= '0;
            dv_reg         <= 1'b0;
            dv_addr_reg    <= '0;
            cmd_reg        <= CMD_WRITE;
            tick_reg       <= '0;
            data_reg       <= '0;
            out_valid_reg  <= 1'b0;
            hit_reg        <= 1'b0;
            found_tick_reg <= '0;
            found_data_reg <= '0;
            count_reg      <= '0;
            status_reg     <= ST_OK;
        end
        else
        begin
            dv_reg      <= (state_reg == S_SCAN);
            dv_addr_reg <= idx_reg;

            if (fin_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_INIT:
                begin
                    if (idx_reg == AW'(TABLE_DEPTH - 1))
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + AW'(1);
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd_reg   <= cmd_t'(cmd);
                        tick_reg  <= tick;
                        data_reg  <= data_word;
                        idx_reg   <= '0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (idx_reg == AW'(TABLE_DEPTH - 1))
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_DRAIN;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + AW'(1);
                    end
                end
                S_DRAIN:
                begin
                    state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    if (out_free)
                    begin
                        hit_reg        <= fin_hit;
                        found_tick_reg <= fin_tick;
                        found_data_reg <= fin_data;
                        count_reg      <= COUNT_OUT_W'(fin_count);
                        status_reg     <= fin_status;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_INIT;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign hit         = hit_reg;
    assign found_tick  = found_tick_reg;
    assign found_data  = found_data_reg;
    assign entry_count = count_reg;
    assign status      = status_reg;

    // The RAM is never written while waiting for a command.
    `THT_ASSERT_HOLDS(a_no_write_idle, state_reg == S_IDLE, !mem_wr_en)
    // An accepted item starts its walk at entry zero.
    `THT_ASSERT_NEXT(a_scan_from_zero, accept, (state_reg == S_SCAN) && (idx_reg == '0))
    // A result only appears out of the final decision cycle.
    `THT_ASSERT_HOLDS(a_result_from_finish, $rose(out_valid_reg), $past(state_reg == S_FINISH))
    // A dropped write means every slot was seen valid.
    `THT_ASSERT_HOLDS(a_full_means_full, (state_reg == S_FINISH) && (cmd_reg == CMD_WRITE) && !flags.exact && !flags.free, valid_cnt == CW'(TABLE_DEPTH))

endmodule
